// ===== rtl/circular_deque_top_assert.svh =====
// ----------------------------------------------------------------------------
// circular_deque_top_assert.svh
// Assertion macros for the circular deque. Each macro expects clk and rst
// in scope and disables the check while rst is high.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CDQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared widths, codes and controller/datapath interface types for the
// circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  // Fixed field widths
  localparam int CAP_W    = 11;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;

  // Default sizing
  localparam int DEF_MAX_DEPTH  = 1024;
  localparam int DEF_DATA_WIDTH = 32;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;        // request taken this cycle
    logic finish_pop;  // read data ready, load pop result
    logic cfg_write;   // capacity write taken this cycle
  } cdq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_read;  // current request is a pop that finds data
    logic full;
    logic empty;
  } cdq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/circular_deque_top.sv =====
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue in a ring memory with a run-time capacity register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   request | in        | in_valid / in_ready  | command, push_value
//   result  | out       | out_valid / out_ready| status, pop_value
//   config  | in        | cfg_valid / cfg_ready| capacity
//
// A push, or any request that ends in an error, loads the result register
// directly; a pop that finds data loads it from the registered ring read.
// A request is taken only when idle and the result register is empty or draining.
// Reset empties the deque and sets capacity to 1024; the ring memory is not
// cleared, since no entry is read before it is written.
// A capacity write also empties the deque.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_deque_top_assert.svh"

module circular_deque_top import cdq_pkg::*; #(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [CMD_W-1:0]          command,
  input  wire logic signed [VALUE_W-1:0] push_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [STATUS_W-1:0]            status,
  output logic signed [VALUE_W-1:0]      pop_value,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CAP_W-1:0]          capacity
);

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  // Sequence requests
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the ring and the indices
  cdq_datapath #(
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (command),
    .push_value (push_value),
    .capacity   (capacity),
    .status     (status),
    .pop_value  (pop_value)
  );

  // Checks
  `CDQ_ASSERT_SAME(a_take_needs_slot, in_ready, (!out_valid || out_ready), "request taken over pending result")
  `CDQ_ASSERT_NEXT(a_pop_waits_read, (cmd.exec && stat.is_read), (!in_ready && !out_valid), "pop read not given its wait cycle")
  `CDQ_ASSERT_NEXT(a_quick_result, (cmd.exec && !stat.is_read), out_valid, "push or error result missing")
  `CDQ_ASSERT_SAME(a_full_empty, 1'b1, !(stat.full && stat.empty), "deque full and empty at once")

endmodule

`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller for the circular deque: sequences each request, waits in S_READ
// for the registered ring read on a pop, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl import cdq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire cdq_stat_t stat,
  output cdq_cmd_t       cmd
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_READ = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       out_valid_next;

  // Handshakes and commands
  always_comb begin
    in_ready       = (state == S_IDLE) && (!out_valid || out_ready);
    cfg_ready      = (state == S_IDLE);
    cmd.exec       = in_valid && in_ready;
    cmd.finish_pop = (state == S_READ);
    cmd.cfg_write  = cfg_valid && cfg_ready;
  end

  // Next state and result valid
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (cmd.exec) begin
          if (stat.is_read) begin
            state_next = S_READ;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_READ: begin
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// cdq_datapath
// Datapath for the circular deque: ring memory, front/back indices,
// occupancy count, capacity register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_datapath import cdq_pkg::*; #(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cdq_cmd_t                   cmd,
  output cdq_stat_t                       stat,
  input  wire logic [CMD_W-1:0]           command,
  input  wire logic signed [VALUE_W-1:0]  push_value,
  input  wire logic [CAP_W-1:0]           capacity,
  output logic [STATUS_W-1:0]             status,
  output logic signed [VALUE_W-1:0]       pop_value
);

  localparam int IDX_W  = $clog2(MAX_DEPTH);
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int WIDE_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  logic [DATA_WIDTH-1:0] mem [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [VALUE_W-1:0]    rd_ext;

  logic [CAP_W-1:0]  cap_reg;
  logic [IDX_W-1:0]  front;
  logic [IDX_W-1:0]  back;
  logic [CNT_W-1:0]  occ;
  logic [IDX_W-1:0]  front_next;
  logic [IDX_W-1:0]  back_next;
  logic [CNT_W-1:0]  occ_next;

  logic [WIDE_W-1:0] cap_wide;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  cap_m1_w;
  logic [IDX_W-1:0]  cap_m1;
  logic [CNT_W-1:0]  front_inc;
  logic [CNT_W-1:0]  back_inc;
  logic [IDX_W-1:0]  front_up;
  logic [IDX_W-1:0]  front_dn;
  logic [IDX_W-1:0]  back_up;
  logic [IDX_W-1:0]  back_dn;

  logic              is_push;
  logic              wr_en;
  logic              rd_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [STATUS_W-1:0] quick_status;

  // Clamp capacity to 1..MAX_DEPTH
  always_comb begin
    cap_wide = WIDE_W'(cap_reg);
    if (cap_wide == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > WIDE_W'(MAX_DEPTH)) begin
      cap_eff = CNT_W'(MAX_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_wide);
    end
    cap_m1_w = cap_eff - CNT_W'(1);
    cap_m1   = cap_m1_w[IDX_W-1:0];
  end

  // Wrapped index moves
  always_comb begin
    front_inc = CNT_W'(front) + CNT_W'(1);
    back_inc  = CNT_W'(back) + CNT_W'(1);
    front_up  = (front_inc >= cap_eff) ? '0 : front_inc[IDX_W-1:0];
    back_up   = (back_inc >= cap_eff) ? '0 : back_inc[IDX_W-1:0];
    front_dn  = (front == '0) ? cap_m1 : front - IDX_W'(1);
    back_dn   = (back == '0) ? cap_m1 : back - IDX_W'(1);
  end

  // Request decode and status
  always_comb begin
    is_push      = (command == CMD_PUSH_BACK) || (command == CMD_PUSH_FRONT);
    stat.full    = (occ >= cap_eff);
    stat.empty   = (occ == '0);
    stat.is_read = !is_push && !stat.empty;
    wr_en        = cmd.exec && is_push && !stat.full;
    rd_en        = cmd.exec && stat.is_read;
    rd_addr      = (command == CMD_POP_BACK) ? back : front;
    quick_status = (is_push && !stat.full) ? ST_PUSHED : ST_ERROR;
  end

  // Next indices, write address and occupancy
  always_comb begin
    front_next = front;
    back_next  = back;
    occ_next   = occ;
    wr_addr    = '0;
    if (is_push && !stat.full) begin
      occ_next = occ + CNT_W'(1);
      if (stat.empty) begin
        front_next = '0;
        back_next  = '0;
      end else if (command == CMD_PUSH_BACK) begin
        back_next = back_up;
        wr_addr   = back_up;
      end else begin
        front_next = front_dn;
        wr_addr    = front_dn;
      end
    end else if (stat.is_read) begin
      occ_next = occ - CNT_W'(1);
      if (occ == CNT_W'(1)) begin
        front_next = '0;
        back_next  = '0;
      end else if (command == CMD_POP_BACK) begin
        back_next = back_dn;
      end else begin
        front_next = front_up;
      end
    end
  end

  // Fit the push value into a ring entry and widen the read entry back out
  generate
    if (DATA_WIDTH < VALUE_W) begin : g_narrow
      assign wr_data = push_value[DATA_WIDTH-1:0];
      assign rd_ext  = {{(VALUE_W - DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
    end else if (DATA_WIDTH == VALUE_W) begin : g_equal
      assign wr_data = push_value;
      assign rd_ext  = rd_data;
    end else begin : g_wide
      assign wr_data = {{(DATA_WIDTH - VALUE_W){1'b0}}, push_value};
      assign rd_ext  = rd_data[VALUE_W-1:0];
    end
  endgenerate

  // Ring memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state: capacity, indices, occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
      front   <= '0;
      back    <= '0;
      occ     <= '0;
    end else if (cmd.cfg_write) begin
      cap_reg <= capacity;
      front   <= '0;
      back    <= '0;
      occ     <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      back  <= back_next;
      occ   <= occ_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec && !stat.is_read) begin
      status    <= quick_status;
      pop_value <= '0;
    end else if (cmd.finish_pop) begin
      status    <= ST_POPPED;
      pop_value <= rd_ext;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_circular_deque_top.sv =====
// ----------------------------------------------------------------------------
// tb_circular_deque_top
// Self-checking bench for the ring-store double-ended queue. A scoreboard
// mirrors the deque state (ring entries, front/back indices, occupancy and
// capacity) and predicts status and pop_value for every accepted request.
// Directed requests cover empty/full errors, index wrap, extreme values and
// the capacity clamps; random traffic then runs under a series of capacities
// with random idle gaps on both the request and result sides.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
  logic [cdq_pkg::STATUS_W-1:0] status;
  logic [cdq_pkg::VALUE_W-1:0]  value;
} deque_result_t;

class deque_scoreboard;
  localparam int RING_IDX_W = $clog2(cdq_pkg::DEF_MAX_DEPTH);

  logic [cdq_pkg::VALUE_W-1:0] ring [cdq_pkg::DEF_MAX_DEPTH];
  int unsigned                 front_idx;
  int unsigned                 back_idx;
  int unsigned                 fill;
  logic [cdq_pkg::CAP_W-1:0]   cap_reg;
  deque_result_t               owed_results [$];
  int                          failures;

  function new();
    cap_reg   = cdq_pkg::CAP_RESET;
    front_idx = 0;
    back_idx  = 0;
    fill      = 0;
    failures  = 0;
  endfunction

  // Clamp the capacity register to the usable ring size
  function int unsigned ring_limit();
    int unsigned lim;
    lim = 32'(cap_reg);
    if (lim == 0) lim = 1;
    if (lim > cdq_pkg::DEF_MAX_DEPTH) lim = cdq_pkg::DEF_MAX_DEPTH;
    return lim;
  endfunction

  // A capacity write also empties the deque
  function void set_capacity(logic [cdq_pkg::CAP_W-1:0] cap);
    cap_reg   = cap;
    fill      = 0;
    front_idx = 0;
    back_idx  = 0;
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  // Advance the deque by one request and queue its result
  function void apply_request(logic [cdq_pkg::CMD_W-1:0] cmd,
                              logic [cdq_pkg::VALUE_W-1:0] val);
    int unsigned   lim;
    deque_result_t res;
    lim        = ring_limit();
    res.status = cdq_pkg::ST_ERROR;
    res.value  = '0;
    if (cmd == cdq_pkg::CMD_PUSH_BACK || cmd == cdq_pkg::CMD_PUSH_FRONT) begin
      if (fill < lim) begin
        if (fill == 0) begin
          front_idx = 0;
          back_idx  = 0;
          ring[0]   = val;
        end else if (cmd == cdq_pkg::CMD_PUSH_BACK) begin
          back_idx = (back_idx + 1 >= lim) ? 0 : back_idx + 1;
          ring[RING_IDX_W'(back_idx)] = val;
        end else begin
          front_idx = (front_idx == 0) ? lim - 1 : front_idx - 1;
          ring[RING_IDX_W'(front_idx)] = val;
        end
        fill++;
        res.status = cdq_pkg::ST_PUSHED;
      end
    end else if (fill != 0) begin
      if (cmd == cdq_pkg::CMD_POP_BACK) begin
        res.value = ring[RING_IDX_W'(back_idx)];
        back_idx  = (back_idx == 0) ? lim - 1 : back_idx - 1;
      end else begin
        res.value = ring[RING_IDX_W'(front_idx)];
        front_idx = (front_idx + 1 >= lim) ? 0 : front_idx + 1;
      end
      fill--;
      // last element gone: both indices return home
      if (fill == 0) begin
        front_idx = 0;
        back_idx  = 0;
      end
      res.status = cdq_pkg::ST_POPPED;
    end
    owed_results.insert(owed_results.size(), res);
  endfunction

  // Compare one result against the oldest owed one
  function void check_result(logic [cdq_pkg::STATUS_W-1:0] st,
                             logic [cdq_pkg::VALUE_W-1:0] val);
    deque_result_t want;
    if (owed_results.size() == 0) begin
      $error("result with none owed: status %0d pop_value %0d", st, $signed(val));
      failures++;
      return;
    end
    want = owed_results[0];
    owed_results.delete(0);
    if (st !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, st);
      failures++;
    end
    if (val !== want.value) begin
      $error("pop_value: expected %0d, actual %0d", $signed(want.value), $signed(val));
      failures++;
    end
  endfunction
endclass

module tb_circular_deque_top;
  import cdq_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    command;
  logic [VALUE_W-1:0]  push_value;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  pop_value;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAP_W-1:0]    capacity;

  deque_scoreboard model = new();
  bit              req_quiet;
  bit              rsp_quiet;
  int              stall_cycles = 0;

  circular_deque_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .pop_value  (pop_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bias values toward the signed extremes
  function automatic logic [VALUE_W-1:0] any_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] any_push();
    return ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
  endfunction

  function automatic logic [CMD_W-1:0] any_pop();
    return ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  // Offer one request after a random gap; hold valid high if no gap follows
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
    int gap;
    if ($urandom_range(0, 15) == 0) req_quiet = !req_quiet;
    gap = req_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    push_value <= val;
    do @(posedge clk); while (!in_ready);
    model.apply_request(cmd, val);
  endtask

  // Drain outstanding results, then write the capacity register
  task automatic load_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    capacity  <= cap;
    do @(posedge clk); while (!cfg_ready);
    model.set_capacity(cap);
    cfg_valid <= 1'b0;
  endtask

  // Random mix of pushes and pops, weighted by push_pct
  task automatic run_traffic(input int n, input int push_pct);
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 99) < push_pct) ? any_push() : any_pop();
      send_request(cmd, any_value());
    end
  endtask

  // Accept results after random stalls and check each one
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 15) == 0) rsp_quiet = !rsp_quiet;
      gap = rsp_quiet ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      model.check_result(status, pop_value);
    end
  end

  // Abort if no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = CMD_PUSH_BACK;
    push_value   = '0;
    cfg_valid    = 1'b0;
    capacity     = CAP_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset capacity: empty errors, front wrap, extremes, last pop
    send_request(CMD_POP_BACK, 32'h1234_5678);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_PUSH_FRONT, 32'h8000_0000);
    send_request(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_request(CMD_PUSH_BACK, 32'h0000_0000);
    send_request(CMD_PUSH_BACK, 32'h0000_0001);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_PUSH_BACK, 32'h5555_aaaa);
    send_request(CMD_PUSH_FRONT, 32'haaaa_5555);

    // Zero capacity acts as one entry; the write also empties the deque
    load_capacity(11'd0);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_PUSH_BACK, 32'h0000_0005);
    send_request(CMD_PUSH_FRONT, 32'h0000_0006);
    send_request(CMD_PUSH_BACK, 32'h0000_0007);
    send_request(CMD_POP_BACK, '0);
    send_request(CMD_POP_FRONT, '0);
    send_request(CMD_PUSH_FRONT, 32'hdead_beef);
    send_request(CMD_POP_FRONT, '0);

    // Random traffic over small, odd and clamped capacities
    load_capacity(11'd1);
    run_traffic(30, 50);
    load_capacity(11'd2);
    run_traffic(40, 55);
    load_capacity(11'd3);
    run_traffic(40, 65);
    load_capacity(11'd4);
    run_traffic(40, 40);
    load_capacity(11'd0);
    run_traffic(25, 50);
    load_capacity(11'd7);
    run_traffic(40, 70);
    load_capacity(11'($urandom_range(5, 40)));
    run_traffic(40, 60);
    load_capacity(11'($urandom_range(1025, 2046)));
    run_traffic(40, 60);
    load_capacity(11'd1023);
    run_traffic(40, 50);
    load_capacity(11'd16);
    run_traffic(40, 50);
    load_capacity(11'd1024);
    run_traffic(35, 35);

    // Largest setting clamps to the full ring
    load_capacity(11'd2047);
    run_traffic(25, 60);

    // Let the last results land
    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (model.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_deque_top.sv
tb/tb_circular_deque_top.sv
